[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/bbc_pkg.sv]
// ---------------------------------------------------------------------------
// bbc_pkg
// Types, codes and defaults shared by the bracket balance checker.
// ---------------------------------------------------------------------------
package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CH_OPEN_PAREN  = 8'h28;
    localparam logic [7:0] CH_OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CH_OPEN_SQUARE = 8'h5B;
    localparam logic [7:0] CH_OPEN_ANGLE  = 8'h3C;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_CLOSE_BRACE  = 8'h7D;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

    localparam logic [1:0] KIND_PAREN  = 2'd0;
    localparam logic [1:0] KIND_BRACE  = 2'd1;
    localparam logic [1:0] KIND_SQUARE = 2'd2;
    localparam logic [1:0] KIND_ANGLE  = 2'd3;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_OPEN  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_MISMATCH = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    localparam logic [2:0] ST_FINE     = 3'd0;
    localparam logic [2:0] ST_BALANCED = 3'd1;
    localparam logic [2:0] ST_MISMATCH = 3'd2;
    localparam logic [2:0] ST_UNCLOSED = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_marker;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        verdict_final;
        logic [10:0] open_depth;
    } out_item_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] kind;
    } token_t;

endpackage

[rtl/core/bbc_fifo.sv]
// ---------------------------------------------------------------------------
// bbc_fifo
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module bbc_fifo #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CNTW-1:0]  cnt_reg;
    logic [CNTW-1:0]  cnt_next;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (cnt_reg == CNTW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/core/bbc_front.sv]
// ---------------------------------------------------------------------------
// bbc_front
// Classify an incoming byte into a stack operation and bracket kind.
// ---------------------------------------------------------------------------
module bbc_front (
    input  bbc_pkg::in_item_t item,
    output bbc_pkg::token_t   token
);

    always_comb
    begin
        token.op   = bbc_pkg::OP_NONE;
        token.kind = bbc_pkg::KIND_PAREN;
        if (item.end_marker)
        begin
            token.op = bbc_pkg::OP_END;
        end
        else
        begin
            unique case (item.text_byte)
                bbc_pkg::CH_OPEN_PAREN:
                begin
                    token.op   = bbc_pkg::OP_OPEN;
                    token.kind = bbc_pkg::KIND_PAREN;
                end
                bbc_pkg::CH_OPEN_BRACE:
                begin
                    token.op   = bbc_pkg::OP_OPEN;
                    token.kind = bbc_pkg::KIND_BRACE;
                end
                bbc_pkg::CH_OPEN_SQUARE:
                begin
                    token.op   = bbc_pkg::OP_OPEN;
                    token.kind = bbc_pkg::KIND_SQUARE;
                end
                bbc_pkg::CH_OPEN_ANGLE:
                begin
                    token.op   = bbc_pkg::OP_OPEN;
                    token.kind = bbc_pkg::KIND_ANGLE;
                end
                bbc_pkg::CH_CLOSE_PAREN:
                begin
                    token.op   = bbc_pkg::OP_CLOSE;
                    token.kind = bbc_pkg::KIND_PAREN;
                end
                bbc_pkg::CH_CLOSE_BRACE:
                begin
                    token.op   = bbc_pkg::OP_CLOSE;
                    token.kind = bbc_pkg::KIND_BRACE;
                end
                bbc_pkg::CH_CLOSE_SQUARE:
                begin
                    token.op   = bbc_pkg::OP_CLOSE;
                    token.kind = bbc_pkg::KIND_SQUARE;
                end
                bbc_pkg::CH_CLOSE_ANGLE:
                begin
                    token.op   = bbc_pkg::OP_CLOSE;
                    token.kind = bbc_pkg::KIND_ANGLE;
                end
                default:
                begin
                    token.op = bbc_pkg::OP_NONE;
                end
            endcase
        end
    end

endmodule

[rtl/core/bbc_back.sv]
// ---------------------------------------------------------------------------
// bbc_back
// Execute stack operations: top of stack in a register, the entry below it
// prefetched from the stack memory, sticky error and verdict generation.
// ---------------------------------------------------------------------------
module bbc_back #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bbc_pkg::token_t     token,
    input  logic                tok_valid,
    output logic                tok_pop,
    output bbc_pkg::out_item_t  result,
    output logic                res_push,
    input  logic                res_full
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W = (CW > 11) ? CW : 11;

    logic [1:0]      mem [STACK_DEPTH];
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [1:0]      err_reg;
    logic [1:0]      err_next;
    logic [1:0]      top_reg;
    logic [1:0]      top_next;
    logic [1:0]      below_reg;
    logic            wr_en;
    logic [CW-1:0]   rd_sum;
    logic [AW-1:0]   rd_addr;
    logic [EXT_W-1:0] depth_ext;
    logic [EXT_W-1:0] count_ext;
    logic            go;

    assign go       = tok_valid && !res_full;
    assign tok_pop  = go;
    assign res_push = go;

    always_comb
    begin
        count_next = count_reg;
        err_next   = err_reg;
        top_next   = top_reg;
        wr_en      = 1'b0;
        if (go)
        begin
            unique case (token.op)
                bbc_pkg::OP_END:
                begin
                    count_next = '0;
                    err_next   = bbc_pkg::ERR_NONE;
                end
                bbc_pkg::OP_OPEN:
                begin
                    if (err_reg == bbc_pkg::ERR_NONE)
                    begin
                        if (count_reg == CW'(STACK_DEPTH))
                        begin
                            err_next = bbc_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            top_next   = token.kind;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                bbc_pkg::OP_CLOSE:
                begin
                    if (err_reg == bbc_pkg::ERR_NONE)
                    begin
                        if (count_reg == '0)
                        begin
                            err_next = bbc_pkg::ERR_MISMATCH;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            top_next   = below_reg;
                            if (top_reg != token.kind)
                            begin
                                err_next = bbc_pkg::ERR_MISMATCH;
                            end
                        end
                    end
                end
                bbc_pkg::OP_NONE:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign rd_sum    = count_next - CW'(2);
    assign rd_addr   = rd_sum[AW-1:0];
    assign count_ext = EXT_W'(count_reg);
    assign depth_ext = EXT_W'(count_next);

    always_comb
    begin
        result.verdict_final = (token.op == bbc_pkg::OP_END);
        result.open_depth    = depth_ext[10:0];
        result.status        = bbc_pkg::ST_FINE;
        if (token.op == bbc_pkg::OP_END)
        begin
            result.open_depth = count_ext[10:0];
            unique case (err_reg)
                bbc_pkg::ERR_MISMATCH: result.status = bbc_pkg::ST_MISMATCH;
                bbc_pkg::ERR_OVERFLOW: result.status = bbc_pkg::ST_OVERFLOW;
                default:
                begin
                    result.status = (count_reg != '0) ? bbc_pkg::ST_UNCLOSED
                                                      : bbc_pkg::ST_BALANCED;
                end
            endcase
        end
        else
        begin
            unique case (err_next)
                bbc_pkg::ERR_MISMATCH: result.status = bbc_pkg::ST_MISMATCH;
                bbc_pkg::ERR_OVERFLOW: result.status = bbc_pkg::ST_OVERFLOW;
                default:               result.status = bbc_pkg::ST_FINE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            err_reg   <= bbc_pkg::ERR_NONE;
        end
        else
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    // Prefetch the entry below the new top every cycle.
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= token.kind;
        end
        below_reg <= mem[rd_addr];
    end

endmodule

[rtl/core/bracket_balance_checker.sv]
// ---------------------------------------------------------------------------
// bracket_balance_checker
// Balanced bracket checker: one text byte per item, an end item closes the
// text and returns the verdict.
// ---------------------------------------------------------------------------
// Input channel: drive item and push; a byte transfers when push is high and
//   full is low. An item with end_marker set ends the current text.
// Result channel: while empty is low, result holds the oldest result; it
//   transfers when pop is high. Every input item yields exactly one result.
// Path: an item transfers into the token queue, the stack unit moves it into
//   the result queue when the result queue has room, and its result then
//   appears on the result ports.
// Throughput: one item per cycle while the result queue has room. The stack
//   unit keeps the top entry in a register and prefetches the entry below it
//   from the stack memory each cycle, so pushes and pops go back to back.
// Stall: when pop stays low the result queue fills, the stack unit holds,
//   then the token queue fills and full rises.
// Reset: both queues empty, depth zero, no error. Stack memory needs no
//   clearing pass; only entries pushed in the current text are read.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
    parameter int QUEUE_DEPTH = bbc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bbc_pkg::in_item_t  item,
    input  logic               push,
    output logic               full,
    output bbc_pkg::out_item_t result,
    output logic               empty,
    input  logic               pop
);

    localparam int TOK_W = $bits(bbc_pkg::token_t);
    localparam int RES_W = $bits(bbc_pkg::out_item_t);

    bbc_pkg::token_t    front_tok;
    bbc_pkg::token_t    back_tok;
    logic [TOK_W-1:0]   tok_rdata;
    logic               tok_empty;
    logic               tok_pop;
    bbc_pkg::out_item_t back_res;
    logic [RES_W-1:0]   res_rdata;
    logic               res_push;
    logic               res_full;
    logic               verdict_bad;
    logic               running_bad;

    bbc_front u_front (
        .item  (item),
        .token (front_tok)
    );

    bbc_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_tok_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_tok),
        .full  (full),
        .pop   (tok_pop),
        .rdata (tok_rdata),
        .empty (tok_empty)
    );

    assign back_tok = bbc_pkg::token_t'(tok_rdata);

    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .token     (back_tok),
        .tok_valid (!tok_empty),
        .tok_pop   (tok_pop),
        .result    (back_res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    bbc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign result = bbc_pkg::out_item_t'(res_rdata);

    assign verdict_bad = !empty && result.verdict_final
                         && (result.status == bbc_pkg::ST_FINE);
    assign running_bad = !empty && !result.verdict_final
                         && (result.status != bbc_pkg::ST_FINE)
                         && (result.status != bbc_pkg::ST_MISMATCH)
                         && (result.status != bbc_pkg::ST_OVERFLOW);

    `ASSERT_NEVER(a_res_push_full, res_push && res_full, "result pushed into full queue")
    `ASSERT_NEVER(a_tok_pop_empty, tok_pop && tok_empty, "token popped from empty queue")
    `ASSERT_NEVER(a_verdict_code, verdict_bad, "verdict carries running status")
    `ASSERT_NEVER(a_running_code, running_bad, "running result carries verdict code")

endmodule
